// File: rtl/obl_pkg.sv
// ----------------------------------------------------------------------------
// obl_pkg
// shared types and defaults for the order book level tracker
// ----------------------------------------------------------------------------
package obl_pkg;

	localparam int BOOK_DEPTH_DEF = 64;
	localparam int PRICE_BITS_DEF = 32;

	typedef struct packed {
		logic        side;
		logic [31:0] level_price;
		logic [31:0] level_amount;
		logic [47:0] msg_time;
		logic        last_in_msg;
	} change_t;

	typedef struct packed {
		logic [47:0] out_time;
		logic [31:0] best_bid_price;
		logic [31:0] best_bid_amount;
		logic [31:0] best_ask_price;
		logic [31:0] best_ask_amount;
		logic        bid_present;
		logic        ask_present;
		logic        overflow_seen;
	} result_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic step;
		logic best;
		logic apply;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic last;
	} status_t;

endpackage

// File: rtl/obl_ctrl.sv
// ----------------------------------------------------------------------------
// obl_ctrl
// sequencer: load, match scan, apply, best scan, result transfer
// ----------------------------------------------------------------------------
module obl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  obl_pkg::status_t sts,
	output obl_pkg::cmd_t   cmd,
	output logic            busy,
	output logic            strobe
);
	import obl_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_MATCH = 6'b000010,
		S_APPLY = 6'b000100,
		S_CLR   = 6'b001000,
		S_BEST  = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					cmd.clear = 1'b1;
					state_d = S_MATCH;
				end
			end
			S_MATCH: begin
				cmd.step = 1'b1;
				if (sts.scan_done) state_d = S_APPLY;
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d = sts.last ? S_CLR : S_IDLE;
			end
			S_CLR: begin
				cmd.clear = 1'b1;
				state_d = S_BEST;
			end
			S_BEST: begin
				cmd.step = 1'b1;
				cmd.best = 1'b1;
				if (sts.scan_done) state_d = S_EMIT;
			end
			S_EMIT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign strobe = (state_q == S_EMIT);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted transfer not busy");
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe) else $error("result strobe longer than one cycle");
	a_apply_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> !cmd.apply) else $error("apply repeated");
	a_emit_after_best: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(cmd.best)) else $error("result without best scan");
endmodule

// File: rtl/obl_datapath.sv
// ----------------------------------------------------------------------------
// obl_datapath
// level tables, scan engine, apply logic and best level registers
// ----------------------------------------------------------------------------
module obl_datapath #(
	parameter int BOOK_DEPTH = obl_pkg::BOOK_DEPTH_DEF,
	parameter int PRICE_BITS = obl_pkg::PRICE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  obl_pkg::change_t change,
	input  obl_pkg::cmd_t    cmd,
	output obl_pkg::status_t sts,
	output obl_pkg::result_t result
);
	import obl_pkg::*;

	localparam int AW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
	localparam int CW = $clog2(BOOK_DEPTH + 1);

	logic [PRICE_BITS-1:0] bid_p_mem [BOOK_DEPTH];
	logic [31:0]           bid_a_mem [BOOK_DEPTH];
	logic [PRICE_BITS-1:0] ask_p_mem [BOOK_DEPTH];
	logic [31:0]           ask_a_mem [BOOK_DEPTH];
	logic [BOOK_DEPTH-1:0] bid_v_q, ask_v_q;

	logic                  side_q, last_q;
	logic [PRICE_BITS-1:0] price_q;
	logic [31:0]           amount_q;
	logic [47:0]           time_q;
	logic                  ovf_q;

	logic [CW-1:0]         cnt_q;
	logic                  rd_v_s1;
	logic [AW-1:0]         idx_s1;
	logic [PRICE_BITS-1:0] bid_p_s1, ask_p_s1;
	logic [31:0]           bid_a_s1, ask_a_s1;

	logic                  hit_q, free_q;
	logic [AW-1:0]         hit_idx_q, free_idx_q;
	logic                  bf_q, af_q;
	logic [PRICE_BITS-1:0] bbp_q, bap_q;
	logic [31:0]           bba_q, baa_q;

	logic [AW-1:0]         rd_addr, wr_addr;
	logic                  more, sel_v, bv, av;
	logic [PRICE_BITS-1:0] sel_p;
	logic                  we_amt, we_price, clr_v;

	assign more    = (cnt_q < CW'(BOOK_DEPTH));
	assign rd_addr = cnt_q[AW-1:0];
	assign sel_v   = side_q ? ask_v_q[idx_s1] : bid_v_q[idx_s1];
	assign sel_p   = side_q ? ask_p_s1 : bid_p_s1;
	assign bv      = bid_v_q[idx_s1];
	assign av      = ask_v_q[idx_s1];
	assign wr_addr = hit_q ? hit_idx_q : free_idx_q;
	assign we_amt   = cmd.apply && (amount_q != '0) && (hit_q || free_q);
	assign we_price = cmd.apply && (amount_q != '0) && !hit_q && free_q;
	assign clr_v    = cmd.apply && (amount_q == '0) && hit_q;

	// table memories
	always_ff @(posedge clk) begin
		bid_p_s1 <= bid_p_mem[rd_addr];
		bid_a_s1 <= bid_a_mem[rd_addr];
		ask_p_s1 <= ask_p_mem[rd_addr];
		ask_a_s1 <= ask_a_mem[rd_addr];
		if (we_price && !side_q) bid_p_mem[wr_addr] <= price_q;
		if (we_price && side_q)  ask_p_mem[wr_addr] <= price_q;
		if (we_amt && !side_q)   bid_a_mem[wr_addr] <= amount_q;
		if (we_amt && side_q)    ask_a_mem[wr_addr] <= amount_q;
	end

	// item register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			side_q   <= change.side;
			last_q   <= change.last_in_msg;
			price_q  <= PRICE_BITS'(change.level_price);
			amount_q <= change.level_amount;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bid_v_q <= '0;
			ask_v_q <= '0;
			time_q  <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (cmd.load) time_q <= change.msg_time;
			if (cmd.apply && (amount_q != '0) && !hit_q && !free_q) ovf_q <= 1'b1;
			if (we_price && !side_q) bid_v_q[wr_addr] <= 1'b1;
			if (we_price && side_q)  ask_v_q[wr_addr] <= 1'b1;
			if (clr_v && !side_q)    bid_v_q[hit_idx_q] <= 1'b0;
			if (clr_v && side_q)     ask_v_q[hit_idx_q] <= 1'b0;
		end
	end

	// scan engine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			rd_v_s1 <= 1'b0;
		end else if (cmd.clear) begin
			cnt_q   <= '0;
			rd_v_s1 <= 1'b0;
		end else if (cmd.step) begin
			rd_v_s1 <= more;
			if (more) cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) idx_s1 <= rd_addr;
		if (cmd.clear) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			bf_q   <= 1'b0;
			af_q   <= 1'b0;
			bbp_q  <= '0;
			bba_q  <= '0;
			bap_q  <= '0;
			baa_q  <= '0;
		end else if (rd_v_s1 && !cmd.best) begin
			if (sel_v && (sel_p == price_q) && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_s1;
			end
			if (!sel_v && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_s1;
			end
		end else if (rd_v_s1 && cmd.best) begin
			if (bv && (!bf_q || bid_p_s1 > bbp_q)) begin
				bf_q  <= 1'b1;
				bbp_q <= bid_p_s1;
				bba_q <= bid_a_s1;
			end
			if (av && (!af_q || ask_p_s1 < bap_q)) begin
				af_q  <= 1'b1;
				bap_q <= ask_p_s1;
				baa_q <= ask_a_s1;
			end
		end
	end

	assign sts.scan_done = !more && !rd_v_s1;
	assign sts.last      = last_q;

	assign result.out_time        = time_q;
	assign result.best_bid_price  = 32'(bbp_q);
	assign result.best_bid_amount = bba_q;
	assign result.best_ask_price  = 32'(bap_q);
	assign result.best_ask_amount = baa_q;
	assign result.bid_present     = bf_q;
	assign result.ask_present     = af_q;
	assign result.overflow_seen   = ovf_q;
endmodule

// File: rtl/order_book_level_tracker.sv
// ----------------------------------------------------------------------------
// order_book_level_tracker
// bid and ask price level tables with best level report per message
// ----------------------------------------------------------------------------
// usage:
//   a level change transfer is taken when start is high and busy is low.
//   the change is matched against its side's table by a scan of BOOK_DEPTH
//   slots (one memory read a cycle), then applied.
//   a change without last_in_msg then returns to idle.
//   a change with last_in_msg then runs a best level scan over both tables
//   in parallel and drives result with strobe high for one cycle.
//   the scans are paced by the single read port of each level memory.
//   the receiver cannot stall: a result is valid only in its strobe cycle.
//   reset empties both tables (valid bits) and clears time and overflow.
// ----------------------------------------------------------------------------
module order_book_level_tracker #(
	parameter int BOOK_DEPTH = obl_pkg::BOOK_DEPTH_DEF,
	parameter int PRICE_BITS = obl_pkg::PRICE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  obl_pkg::change_t change,
	output logic             strobe,
	output obl_pkg::result_t result
);
	import obl_pkg::*;

	cmd_t    cmd;
	status_t sts;

	obl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.strobe (strobe)
	);

	obl_datapath #(
		.BOOK_DEPTH (BOOK_DEPTH),
		.PRICE_BITS (PRICE_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.change (change),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);
endmodule
